FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define SMMA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define SMMA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/smma_pkg.sv
// ---------------------------------------------------------------------------
// smma_pkg
// Types, constants and address helpers of the metadata address pipeline.
// ---------------------------------------------------------------------------
package smma_pkg;

   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 33;
   localparam int TREE_LEVELS = 6;
   localparam int DIV_STEPS   = ADDR_W;
   // input stage, one stage per remainder bit, output stage
   localparam int PIPE_DEPTH  = DIV_STEPS + 2;
   localparam int CNT_W       = $clog2(PIPE_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DATA_BASE = 2'd0,
      CSR_DATA_SIZE = 2'd1,
      CSR_MAC_BASE  = 2'd2,
      CSR_CTR_BASE  = 2'd3
   } smma_csr_type;

   localparam logic [ADDR_W-1:0] LEVEL_BASE [TREE_LEVELS] = '{
      32'd0, 32'd917504, 32'd974848, 32'd978432, 32'd978656, 32'd978677
   };

   // Divisor of the data region remainder: a zero size counts as 2^32
   localparam logic [SIZE_W-1:0] FULL_SIZE = {1'b1, {ADDR_W{1'b0}}};

   typedef struct packed {
      logic [ADDR_W-1:0] data_base;
      logic [SIZE_W-1:0] divisor;
      logic [ADDR_W-1:0] mac_base;
      logic [ADDR_W-1:0] ctr_base;
   } smma_cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]                   addr_sh;
      logic [SIZE_W-1:0]                   rem;
      logic [ADDR_W-1:0]                   mac;
      logic [ADDR_W-1:0]                   ctr;
      logic [TREE_LEVELS-1:0][ADDR_W-1:0]  tree;
   } smma_item_type;

   // Column mod 8, row / 8
   function automatic logic [ADDR_W-1:0] mac_loc(input logic [ADDR_W-1:0] a);
      return {3'b0, a[31:17], 11'b0, a[2:0]};
   endfunction

   // Column mod 4, row / 4
   function automatic logic [ADDR_W-1:0] ctr_loc(input logic [ADDR_W-1:0] a);
      return {2'b0, a[31:16], 12'b0, a[1:0]};
   endfunction

   // (column / 16) mod 8, row / 128
   function automatic logic [ADDR_W-1:0] tree_loc(input logic [ADDR_W-1:0] p);
      return {7'b0, p[31:21], 11'b0, p[6:4]};
   endfunction

   // One restoring remainder step: shift in one dividend bit, subtract if it fits
   function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] rem,
                                                  input logic              dbit,
                                                  input logic [SIZE_W-1:0] dvsr);
      logic [SIZE_W:0] t;
      logic [SIZE_W:0] diff;
      t    = {rem, dbit};
      diff = t - {1'b0, dvsr};
      if (t >= {1'b0, dvsr}) begin
         return diff[SIZE_W-1:0];
      end
      return t[SIZE_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/smma_ifs.sv
// ---------------------------------------------------------------------------
// smma channel interfaces
// Request and response channels with valid / ready handshake.
// ---------------------------------------------------------------------------
interface smma_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] request_address;

   modport source (output valid, output request_address, input ready);
   modport sink   (input valid, input request_address, output ready);
endinterface

interface smma_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_address;
   logic [31:0] mac_address;
   logic [31:0] counter_address;
   logic [31:0] tree_level0_address;
   logic [31:0] tree_level1_address;
   logic [31:0] tree_level2_address;
   logic [31:0] tree_level3_address;
   logic [31:0] tree_level4_address;
   logic [31:0] tree_level5_address;

   modport source (output valid, input ready,
                   output data_address, mac_address, counter_address,
                   output tree_level0_address, tree_level1_address, tree_level2_address,
                   output tree_level3_address, tree_level4_address, tree_level5_address);
   modport sink   (input valid, output ready,
                   input data_address, mac_address, counter_address,
                   input tree_level0_address, tree_level1_address, tree_level2_address,
                   input tree_level3_address, tree_level4_address, tree_level5_address);
endinterface

FILE: hw/rtl/smma_in.sv
// ---------------------------------------------------------------------------
// smma_in
// Entry stage: registers the request, its MAC and counter addresses.
// ---------------------------------------------------------------------------
module smma_in
   import smma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  smma_cfg_type  cfg,
   smma_req_if.sink      req_ch,
   output logic          out_valid,
   input  logic          out_ready,
   output smma_item_type out_item
);

   logic          valid_ff;
   logic          valid_in;
   smma_item_type item_ff;
   smma_item_type item_in;
   logic          take;

   // Accept a beat whenever this stage is empty or drains this cycle
   assign req_ch.ready = !valid_ff || out_ready;
   assign take         = req_ch.valid && req_ch.ready;

   // Build the item: remainder starts at zero, tree levels fill downstream
   always_comb begin
      item_in         = item_ff;
      item_in.addr_sh = req_ch.request_address;
      item_in.rem     = '0;
      item_in.mac     = mac_loc(req_ch.request_address) + cfg.mac_base;
      item_in.ctr     = ctr_loc(req_ch.request_address) + cfg.ctr_base;
      item_in.tree    = '0;
   end

   assign valid_in = take || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until a new beat is taken
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: hw/rtl/smma_div_stage.sv
// ---------------------------------------------------------------------------
// smma_div_stage
// One remainder bit of the data region reduction, plus one tree level
// when LEVEL names one.
// ---------------------------------------------------------------------------
module smma_div_stage
   import smma_pkg::*;
#(
   parameter int LEVEL = 0
)
(
   input  logic          clock,
   input  logic          reset,
   input  smma_cfg_type  cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  smma_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output smma_item_type out_item
);

   logic                               valid_ff;
   logic                               valid_in;
   smma_item_type                      item_ff;
   smma_item_type                      item_in;
   logic [TREE_LEVELS-1:0][ADDR_W-1:0] tree_in;
   logic                               take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Walk one tree level in this stage, or pass the levels through
   if (LEVEL == 0) begin : g_lvl_first
      always_comb begin
         tree_in    = in_item.tree;
         tree_in[0] = tree_loc(in_item.ctr) + LEVEL_BASE[0];
      end
   end else if (LEVEL < TREE_LEVELS) begin : g_lvl_next
      always_comb begin
         tree_in        = in_item.tree;
         tree_in[LEVEL] = tree_loc(in_item.tree[LEVEL-1]) + LEVEL_BASE[LEVEL];
      end
   end else begin : g_lvl_pass
      assign tree_in = in_item.tree;
   end

   // Advance the remainder by the dividend's top bit, then shift it out
   always_comb begin
      item_in         = in_item;
      item_in.rem     = rem_step(in_item.rem, in_item.addr_sh[ADDR_W-1], cfg.divisor);
      item_in.addr_sh = {in_item.addr_sh[ADDR_W-2:0], 1'b0};
      item_in.tree    = tree_in;
   end

   assign valid_in = take || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: hw/rtl/smma_out.sv
// ---------------------------------------------------------------------------
// smma_out
// Output stage: adds the data region base and registers the response beat.
// ---------------------------------------------------------------------------
module smma_out
   import smma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  smma_cfg_type  cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  smma_item_type in_item,
   smma_rsp_if.source    rsp_ch
);

   logic                               valid_ff;
   logic                               valid_in;
   logic [ADDR_W-1:0]                  data_ff;
   logic [ADDR_W-1:0]                  data_in;
   logic [ADDR_W-1:0]                  mac_ff;
   logic [ADDR_W-1:0]                  ctr_ff;
   logic [TREE_LEVELS-1:0][ADDR_W-1:0] tree_ff;
   logic                               take;

   assign in_ready = !valid_ff || rsp_ch.ready;
   assign take     = in_valid && in_ready;

   // Remainder is below the divisor, so its low word is the reduced address
   assign data_in  = in_item.rem[ADDR_W-1:0] + cfg.data_base;
   assign valid_in = take || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
         mac_ff  <= in_item.mac;
         ctr_ff  <= in_item.ctr;
         tree_ff <= in_item.tree;
      end
   end

   assign rsp_ch.valid               = valid_ff;
   assign rsp_ch.data_address        = data_ff;
   assign rsp_ch.mac_address         = mac_ff;
   assign rsp_ch.counter_address     = ctr_ff;
   assign rsp_ch.tree_level0_address = tree_ff[0];
   assign rsp_ch.tree_level1_address = tree_ff[1];
   assign rsp_ch.tree_level2_address = tree_ff[2];
   assign rsp_ch.tree_level3_address = tree_ff[3];
   assign rsp_ch.tree_level4_address = tree_ff[4];
   assign rsp_ch.tree_level5_address = tree_ff[5];

endmodule

FILE: hw/rtl/secure_memory_metadata_addresser_core.sv
// ---------------------------------------------------------------------------
// secure_memory_metadata_addresser_core
// Maps a request address to its data, MAC, counter and integrity tree
// node addresses through a 34-stage pipeline.
// ---------------------------------------------------------------------------
//   channel  direction  beat
//   req_ch   in         request_address
//   rsp_ch   out        data, MAC, counter and six tree level addresses
//   csr_*    in         register write (index, data)
//
// One beat enters per cycle while the pipe is not backed up; each response passes
// the entry, remainder and output stages and leaves when the output takes it.
// The depth comes from the data region remainder, one bit per stage over 32.
// Reset loads the register defaults (region size 2^32) and empties the pipe.
// Each stage holds its beat while the next one is full, and empty stages
// keep taking beats during a response stall.
// ---------------------------------------------------------------------------
module secure_memory_metadata_addresser_core
   import smma_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   smma_req_if.sink             req_ch,
   smma_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   smma_cfg_type  cfg_ff;
   smma_cfg_type  cfg_in;

   logic          stg_valid [DIV_STEPS+1];
   logic          stg_ready [DIV_STEPS+1];
   smma_item_type stg_item  [DIV_STEPS+1];

   // Decode register writes; a zero size stands for the full 2^32 space
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (smma_csr_type'(csr_index))
            CSR_DATA_BASE: cfg_in.data_base = csr_wdata[ADDR_W-1:0];
            CSR_DATA_SIZE: cfg_in.divisor   = (csr_wdata == '0) ? FULL_SIZE : csr_wdata;
            CSR_MAC_BASE:  cfg_in.mac_base  = csr_wdata[ADDR_W-1:0];
            CSR_CTR_BASE:  cfg_in.ctr_base  = csr_wdata[ADDR_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_base <= '0;
         cfg_ff.divisor   <= FULL_SIZE;
         cfg_ff.mac_base  <= '0;
         cfg_ff.ctr_base  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   smma_in u_in (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_ch    (req_ch),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_item  (stg_item[0])
   );

   // Remainder chain; the first six stages also walk the tree levels
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      smma_div_stage #(
         .LEVEL (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .cfg       (cfg_ff),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_item   (stg_item[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_item  (stg_item[k+1])
      );
   end

   smma_out u_out (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (stg_valid[DIV_STEPS]),
      .in_ready (stg_ready[DIV_STEPS]),
      .in_item  (stg_item[DIV_STEPS]),
      .rsp_ch   (rsp_ch)
   );

endmodule

FILE: hw/rtl/smma_checker.sv
// ---------------------------------------------------------------------------
// smma_checker
// Port-level checks on the metadata address pipeline, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smma_checker
   import smma_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_data,
   input logic [ADDR_W-1:0] rsp_tree5
);

   logic [CNT_W-1:0] pend_ff;
   logic [CNT_W-1:0] pend_in;
   logic             req_beat;
   logic             rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Track beats inside the pipe
   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat) begin
         pend_in = pend_ff + CNT_W'(1);
      end else if (rsp_beat && !req_beat) begin
         pend_in = pend_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `SMMA_ASSERT_ALWAYS(a_empty_after_reset, reset |=> !rsp_valid, "response valid after reset")
   `SMMA_ASSERT(a_no_phantom, rsp_valid |-> (pend_ff != '0), "response with no request pending")
   `SMMA_ASSERT(a_depth_bound, pend_ff <= CNT_W'(PIPE_DEPTH), "more beats pending than stages")
   `SMMA_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data) && $stable(rsp_tree5)), "stalled response changed")

endmodule

bind secure_memory_metadata_addresser_core smma_checker u_smma_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data_address),
   .rsp_tree5 (rsp_ch.tree_level5_address)
);

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// Metadata addresser testbench
// Sends request beats through the metadata address pipeline and checks every
// response beat, field by field, against an in-bench calculator or a typed-in map.
// A directed table covers reset, register extremes and region size corners;
// random register settings and addresses follow, with random gaps on both
// channels, one long response stall and one stretch with no gaps at all.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
   import smma_pkg::*;
();

   // Fields of one response beat, data address first
   typedef logic [0:8][ADDR_W-1:0] meta_map_type;

   typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      smma_csr_type      reg_idx;
      logic [SIZE_W-1:0] value;
      logic [ADDR_W-1:0] addr;
      bit                typed;
      meta_map_type      want;
   } dir_row_type;

   localparam int F_DATA       = 0;
   localparam int F_MAC        = 1;
   localparam int F_CTR        = 2;
   localparam int F_TREE       = 3;
   localparam int DIR_ROWS     = 33;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 125;
   localparam int PRESSURE_AT  = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int CALM_FROM    = 600;
   localparam int CALM_TO      = 800;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;

   localparam logic [ADDR_W-1:0] NODE_BASE [TREE_LEVELS] = '{
      32'd0, 32'd917504, 32'd974848, 32'd978432, 32'd978656, 32'd978677
   };

   string field_names [9] = '{
      "data_address", "mac_address", "counter_address",
      "tree_level0_address", "tree_level1_address", "tree_level2_address",
      "tree_level3_address", "tree_level4_address", "tree_level5_address"
   };

   // Directed stimulus: register writes and request beats in order
   dir_row_type dir_table [DIR_ROWS] = '{
      '{ROW_ITEM, CSR_DATA_BASE, 33'h0, 32'h0000_0000, 1'b1,
        {32'd0, 32'd0, 32'd0, 32'd0, 32'd917504,
         32'd974848, 32'd978432, 32'd978656, 32'd978683}},
      '{ROW_ITEM, CSR_DATA_BASE, 33'h0, 32'hFFFF_FFFF, 1'b1,
        {32'hFFFF_FFFF, 32'h1FFF_C007, 32'h3FFF_C003, 32'h007F_C000, 32'h000E_C000,
         32'd974848, 32'd978432, 32'd978656, 32'd978683}},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h0000_3FFF, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hFFFF_C000, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h5555_5555, 1'b0, '0},
      // all bases at the top so the MAC and counter sums wrap; region of one address
      '{ROW_WRITE, CSR_DATA_BASE, 33'h0_FFFF_FFFF, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h0_0000_0001, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_MAC_BASE,  33'h0_FFFF_FFFF, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_CTR_BASE,  33'h0_FFFF_FFFF, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h1234_5678, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hFFFF_FFFF, 1'b0, '0},
      // zero size passes the address unreduced
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h0_0000_0000, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_DATA_BASE, 33'h0_0000_0010, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h0000_0000, 1'b0, '0},
      // size above 2^32 also leaves the address alone
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h1_FFFF_FFFF, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_DATA_BASE, 33'h0_0000_0000, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hDEAD_BEEF, 1'b0, '0},
      // largest size that still reduces
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h0_FFFF_FFFF, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'hFFFF_FFFE, 1'b0, '0},
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h1_0000_0000, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h8000_0000, 1'b0, '0},
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h0_0000_0003, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_MAC_BASE,  33'h0_0000_0000, 32'h0,         1'b0, '0},
      '{ROW_WRITE, CSR_CTR_BASE,  33'h0_0000_0000, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h7FFF_FFFF, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h8000_0000, 1'b0, '0},
      '{ROW_WRITE, CSR_DATA_SIZE, 33'h0_8000_0000, 32'h0,         1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h8000_0000, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h7FFF_FFFF, 1'b0, '0},
      '{ROW_ITEM,  CSR_DATA_BASE, 33'h0,           32'h0000_0001, 1'b0, '0}
   };

   logic              clock;
   logic              reset;
   logic              csr_we;
   smma_csr_type      csr_index;
   logic [SIZE_W-1:0] csr_wdata;

   smma_req_if req_ch ();
   smma_rsp_if rsp_ch ();

   // Register copy used by the address calculator
   logic [ADDR_W-1:0] data_base   = '0;
   logic [SIZE_W-1:0] region_size = FULL_SIZE;
   logic [ADDR_W-1:0] mac_base    = '0;
   logic [ADDR_W-1:0] ctr_base    = '0;

   meta_map_type pending_maps [$];
   meta_map_type typed_map;
   bit           use_typed     = 1'b0;
   bit           pressure_done = 1'b0;
   int           n_in          = 0;
   int           n_out         = 0;
   int           n_err         = 0;
   int           n_directed    = 0;
   int           n_settings    = 1;

   secure_memory_metadata_addresser_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Column in the low 14 bits, row above
   function automatic logic [ADDR_W-1:0] join_addr(input logic [13:0] col,
                                                    input logic [17:0] row);
      return {row, col};
   endfunction

   // Compute data, MAC, counter and tree node addresses of one request
   function automatic meta_map_type map_request(input logic [ADDR_W-1:0] a);
      meta_map_type      m;
      logic [SIZE_W-1:0] rem;
      logic [ADDR_W-1:0] node;
      int                k;
      if (region_size == '0 || region_size[ADDR_W]) begin
         rem = {1'b0, a};
      end else begin
         rem = {1'b0, a} % region_size;
      end
      m[F_DATA] = rem[ADDR_W-1:0] + data_base;
      m[F_MAC]  = join_addr(a[13:0] % 14'd8, a[31:14] / 18'd8) + mac_base;
      m[F_CTR]  = join_addr(a[13:0] % 14'd4, a[31:14] / 18'd4) + ctr_base;
      node = m[F_CTR];
      for (k = 0; k < TREE_LEVELS; k++) begin
         node = join_addr((node[13:0] / 14'd16) % 14'd8, node[31:14] / 18'd128)
                + NODE_BASE[k];
         m[F_TREE + k] = node;
      end
      return m;
   endfunction

   function automatic bit calm();
      return n_in >= CALM_FROM && n_in < CALM_TO;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_base();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return {18'($urandom), 14'h3FFF};
         3:       return {18'h3FFFF, 14'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Wait for the pipe to empty, then write one register
   task automatic write_reg(input smma_csr_type idx, input logic [SIZE_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (pending_maps.size() != 0) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      case (idx)
         CSR_DATA_BASE: data_base   = value[ADDR_W-1:0];
         CSR_DATA_SIZE: region_size = value;
         CSR_MAC_BASE:  mac_base    = value[ADDR_W-1:0];
         CSR_CTR_BASE:  ctr_base    = value[ADDR_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one request beat, with a random gap ahead of it
   task automatic send_request(input logic [ADDR_W-1:0] a, input bit typed,
                               input meta_map_type want);
      csr_we <= 1'b0;
      while (!calm() && $urandom_range(0, 99) < 8) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      use_typed = typed;
      typed_map = want;
      req_ch.valid           <= 1'b1;
      req_ch.request_address <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_map(input meta_map_type want, input meta_map_type got);
      int i;
      for (i = 0; i < 9; i++) begin
         if (want[i] !== got[i]) begin
            $error("%s: expected %h, actual %h", field_names[i], want[i], got[i]);
            n_err++;
         end
      end
   endtask

   // Record accepted requests and check response beats in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            pending_maps.insert(pending_maps.size(),
                                use_typed ? typed_map : map_request(req_ch.request_address));
            n_in++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_maps.size() == 0) begin
               $error("response beat with no request outstanding");
               n_err++;
            end else begin
               check_map(pending_maps.pop_front(),
                         {rsp_ch.data_address, rsp_ch.mac_address, rsp_ch.counter_address,
                          rsp_ch.tree_level0_address, rsp_ch.tree_level1_address,
                          rsp_ch.tree_level2_address, rsp_ch.tree_level3_address,
                          rsp_ch.tree_level4_address, rsp_ch.tree_level5_address});
            end
            n_out++;
         end
      end
   end

   // Response side: random stalls, one long hold, no stalls in the calm stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!pressure_done && n_in >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ch.ready <= calm() || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   // Stimulus: reset, directed table, then random phases
   initial begin
      int                p;
      int                i;
      int                r;
      logic [SIZE_W-1:0] size;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_DATA_BASE;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.request_address = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table
      for (r = 0; r < DIR_ROWS; r++) begin
         if (dir_table[r].kind == ROW_WRITE) begin
            write_reg(dir_table[r].reg_idx, dir_table[r].value);
            n_settings++;
         end else begin
            send_request(dir_table[r].addr, dir_table[r].typed, dir_table[r].want);
            n_directed++;
         end
      end

      // random register settings, each followed by a batch of requests
      for (p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 6))
            0:       size = '0;
            1:       size = FULL_SIZE;
            2:       size = {1'b1, 32'($urandom)};
            3:       size = 33'($urandom_range(1, 16));
            4:       size = 33'(1) << $urandom_range(0, 31);
            5:       size = 33'h0_FFFF_FFFF;
            default: size = {1'b0, 32'($urandom)};
         endcase
         write_reg(CSR_DATA_BASE, {1'b0, pick_base()});
         write_reg(CSR_DATA_SIZE, size);
         write_reg(CSR_MAC_BASE, {1'b0, pick_base()});
         write_reg(CSR_CTR_BASE, {1'b0, pick_base()});
         n_settings++;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_request(pick_address(), 1'b0, '0);
         end
      end

      // drain, then let the clock run on to catch stray beats
      req_ch.valid <= 1'b0;
      while (pending_maps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d request beats (%0d directed) under %0d register settings,",
               n_in, n_directed, n_settings);
      $display("%0d response beats checked, including one long response stall.", n_out);
      if (n_err == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
